// ===== rtl/fst_pkg.sv =====
// Shared types and constants of the flow session table.
// Used by the entry cell and the top level.
package fst_pkg;

   localparam int FLOW_ENTRIES_DEF = 256;
   localparam int SESSION_ID_W     = 9;
   localparam int STAMP_W          = 63;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   typedef struct packed {
      logic [63:0] src_hi;
      logic [63:0] src_lo;
      logic [63:0] dst_hi;
      logic [63:0] dst_lo;
      logic [31:0] ports;
      logic        is_udp;
   } key_type;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [7:0]         app;
      logic [15:0]        len;
   } upd_type;

   typedef struct packed {
      logic lookup;
      logic update;
      logic miss;
   } ctl_type;

   typedef struct packed {
      logic [SESSION_ID_W-1:0] id;
      logic [31:0]             pkt;
      logic [STAMP_W-1:0]      bytes;
      logic [STAMP_W-1:0]      first;
      logic [STAMP_W-1:0]      last;
      logic [7:0]              app;
   } view_type;

endpackage

// ===== rtl/fst_req_if.sv =====
// Packet descriptor channel of the flow session table.
// Depends on nothing; valid/ready handshake with the descriptor fields.
interface fst_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] src_addr_hi;
   logic [63:0] src_addr_lo;
   logic [63:0] dst_addr_hi;
   logic [63:0] dst_addr_lo;
   logic [15:0] sport;
   logic [15:0] dport;
   logic [7:0]  ip_proto;
   logic [7:0]  app_id;
   logic [62:0] timestamp;
   logic [15:0] frame_len;

   modport source (output valid, src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo,
                   sport, dport, ip_proto, app_id, timestamp, frame_len,
                   input ready);
   modport sink (input valid, src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo,
                 sport, dport, ip_proto, app_id, timestamp, frame_len,
                 output ready);
endinterface

// ===== rtl/fst_rsp_if.sv =====
// Session result channel of the flow session table.
// Depends on nothing; valid/ready handshake with the result fields.
interface fst_rsp_if;
   logic        valid;
   logic        ready;
   logic        tracked;
   logic        is_new;
   logic        table_full;
   logic [8:0]  sess_num;
   logic [31:0] packet_total;
   logic [62:0] byte_total;
   logic [62:0] first_seen;
   logic [62:0] last_seen;
   logic [7:0]  session_app;

   modport source (output valid, tracked, is_new, table_full, sess_num, packet_total,
                   byte_total, first_seen, last_seen, session_app, input ready);
   modport sink (input valid, tracked, is_new, table_full, sess_num, packet_total,
                 byte_total, first_seen, last_seen, session_app, output ready);
endinterface

// ===== rtl/fst_cell.sv =====
// One flow entry of the session table: stored key, counters and stamps.
// Depends on fst_pkg for the key, update, control and view types.
module fst_cell
   import fst_pkg::*;
#(
   parameter int USED_W   = 9,
   parameter int CELL_IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  key_type           key,
   input  upd_type           upd,
   input  ctl_type           ctl,
   input  logic [USED_W-1:0] used,
   output logic              hit,
   output view_type          view
);

   localparam logic [USED_W-1:0] MY_IDX = USED_W'(CELL_IDX);
   localparam logic [SESSION_ID_W-1:0] MY_ID = SESSION_ID_W'(CELL_IDX + 1);
   localparam logic [STAMP_W-1:0] BYTE_MAX = '1;

   logic               valid_ff, valid_in;
   logic               match_ff, match_in;
   logic               sel_ff, sel_in;
   key_type            key_ff, key_in;
   logic [31:0]        pkt_ff, pkt_in;
   logic [STAMP_W-1:0] bytes_ff, bytes_in;
   logic [STAMP_W-1:0] first_ff, first_in;
   logic [STAMP_W-1:0] last_ff, last_in;
   logic [7:0]         app_ff, app_in;
   logic               do_match, do_alloc;
   logic [STAMP_W:0]   byte_sum;

   assign do_match = ctl.update & match_ff;
   assign do_alloc = ctl.update & ctl.miss & (used == MY_IDX);
   assign byte_sum = {1'b0, bytes_ff} + {{(STAMP_W - 15){1'b0}}, upd.len};

   always_comb begin
      valid_in = valid_ff;
      match_in = match_ff;
      sel_in   = sel_ff;
      key_in   = key_ff;
      pkt_in   = pkt_ff;
      bytes_in = bytes_ff;
      first_in = first_ff;
      last_in  = last_ff;
      app_in   = app_ff;
      if (ctl.lookup) begin
         match_in = valid_ff & (key_ff == key);
         sel_in   = 1'b0;
      end
      if (do_alloc) begin
         valid_in = 1'b1;
         sel_in   = 1'b1;
         key_in   = key;
         pkt_in   = 32'd1;
         bytes_in = {{(STAMP_W - 16){1'b0}}, upd.len};
         first_in = upd.stamp;
         last_in  = upd.stamp;
         app_in   = upd.app;
      end else if (do_match) begin
         sel_in  = 1'b1;
         last_in = upd.stamp;
         if (upd.app != 8'd0) begin
            app_in = upd.app;
         end
         if (pkt_ff != 32'hFFFF_FFFF) begin
            pkt_in = pkt_ff + 32'd1;
         end
         bytes_in = byte_sum[STAMP_W] ? BYTE_MAX : byte_sum[STAMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
         sel_ff   <= sel_in;
      end
      key_ff   <= key_in;
      pkt_ff   <= pkt_in;
      bytes_ff <= bytes_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      app_ff   <= app_in;
   end

   assign hit = match_ff;

   // Only the cell touched by the current packet drives the gather bus.
   always_comb begin
      view = '0;
      if (sel_ff) begin
         view.id    = MY_ID;
         view.pkt   = pkt_ff;
         view.bytes = bytes_ff;
         view.first = first_ff;
         view.last  = last_ff;
         view.app   = app_ff;
      end
   end

endmodule

// ===== rtl/flow_session_table.sv =====
// Exact-match TCP/UDP session table: a row of entry cells and the sequencer.
// Depends on fst_pkg, fst_req_if, fst_rsp_if and fst_cell.
//
// The req channel carries one packet descriptor per beat, the rsp channel one
// session result per beat; both use valid/ready. A descriptor is taken only
// when the block is idle. Each entry cell compares its stored key with the
// broadcast key in the lookup state, the matching or newly allocated cell
// updates itself in the update state, and in the gather state the touched
// cell's contents are gathered into the result register. A packet that is
// neither TCP nor UDP goes from idle straight to the output state, and one
// that misses on a full table goes there from the update state. The result
// stays on rsp until taken, and no new descriptor is accepted meanwhile.
// Reset invalidates all entries and clears the session counter; no clearing
// pass is needed.
module flow_session_table
   import fst_pkg::*;
#(
   parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
   input  logic  clock,
   input  logic  reset,
   fst_req_if.sink   req,
   fst_rsp_if.source rsp
);

   localparam int USED_W = $clog2(FLOW_ENTRIES + 1);
   localparam logic [USED_W-1:0] USED_MAX = USED_W'(FLOW_ENTRIES);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOOK = 3'd1;
   localparam logic [2:0] ST_UPD  = 3'd2;
   localparam logic [2:0] ST_GATH = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [USED_W-1:0] used_ff, used_in;
   key_type           key_ff, key_in;
   upd_type           upd_ff, upd_in;
   logic              miss_ff, miss_in;
   logic              tracked_ff, tracked_in;
   logic              new_ff, new_in;
   logic              full_ff, full_in;
   view_type          res_ff, res_in;
   ctl_type           ctl;
   logic [FLOW_ENTRIES-1:0] hits;
   view_type          views [FLOW_ENTRIES];
   view_type          gather;
   logic              any_hit;
   logic              accept;
   logic              is_tcp, is_udp;

   assign accept  = req.valid & req.ready;
   assign is_tcp  = (req.ip_proto == PROTO_TCP);
   assign is_udp  = (req.ip_proto == PROTO_UDP);
   assign any_hit = |hits;

   always_comb begin
      ctl.lookup = (state_ff == ST_LOOK);
      ctl.update = (state_ff == ST_UPD) & (any_hit | (used_ff != USED_MAX));
      ctl.miss   = ~any_hit;
   end

   for (genvar g = 0; g < FLOW_ENTRIES; g++) begin : g_cell
      fst_cell #(
         .USED_W   (USED_W),
         .CELL_IDX (g)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .key   (key_ff),
         .upd   (upd_ff),
         .ctl   (ctl),
         .used  (used_ff),
         .hit   (hits[g]),
         .view  (views[g])
      );
   end

   always_comb begin
      gather = '0;
      for (int i = 0; i < FLOW_ENTRIES; i++) begin
         gather = gather | views[i];
      end
   end

   always_comb begin
      state_in   = state_ff;
      used_in    = used_ff;
      key_in     = key_ff;
      upd_in     = upd_ff;
      miss_in    = miss_ff;
      tracked_in = tracked_ff;
      new_in     = new_ff;
      full_in    = full_ff;
      res_in     = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in.src_hi = req.src_addr_hi;
               key_in.src_lo = req.src_addr_lo;
               key_in.dst_hi = req.dst_addr_hi;
               key_in.dst_lo = req.dst_addr_lo;
               key_in.ports  = {req.sport, req.dport};
               key_in.is_udp = is_udp;
               upd_in.stamp  = req.timestamp;
               upd_in.app    = req.app_id;
               upd_in.len    = req.frame_len;
               tracked_in    = is_tcp | is_udp;
               new_in        = 1'b0;
               full_in       = 1'b0;
               res_in        = '0;
               state_in      = (is_tcp | is_udp) ? ST_LOOK : ST_OUT;
            end
         end
         ST_LOOK: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            miss_in = ~any_hit;
            if (!any_hit && used_ff == USED_MAX) begin
               full_in  = 1'b1;
               state_in = ST_OUT;
            end else begin
               if (!any_hit) begin
                  used_in = used_ff + USED_W'(1);
               end
               state_in = ST_GATH;
            end
         end
         ST_GATH: begin
            res_in   = gather;
            new_in   = miss_ff;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
      key_ff     <= key_in;
      upd_ff     <= upd_in;
      miss_ff    <= miss_in;
      tracked_ff <= tracked_in;
      new_ff     <= new_in;
      full_ff    <= full_in;
      res_ff     <= res_in;
   end

   assign req.ready        = (state_ff == ST_IDLE);
   assign rsp.valid        = (state_ff == ST_OUT);
   assign rsp.tracked      = tracked_ff;
   assign rsp.is_new       = new_ff;
   assign rsp.table_full   = full_ff;
   assign rsp.sess_num     = res_ff.id;
   assign rsp.packet_total = res_ff.pkt;
   assign rsp.byte_total   = res_ff.bytes;
   assign rsp.first_seen   = res_ff.first;
   assign rsp.last_seen    = res_ff.last;
   assign rsp.session_app  = res_ff.app;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_MAX)
      else $error("session counter beyond table size");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPD |-> $onehot0(hits))
      else $error("more than one entry matches a key");

   a_untracked_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.tracked |-> rsp.sess_num == '0 && !rsp.is_new)
      else $error("untracked packet reports a session");

   a_new_first: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.is_new |-> rsp.packet_total == 32'd1
                                  && rsp.first_seen == rsp.last_seen)
      else $error("new session with stale counters");

   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPD && !any_hit && used_ff != USED_MAX
         |=> used_ff == $past(used_ff) + 1'b1)
      else $error("allocation did not advance the session counter");

endmodule
